[design/dtq_pkg.sv]
// dtq_pkg: shared types and codes of the delta timer queue
// command and result codes, controller states, datapath commands and status
// no dependencies
`default_nettype none

package dtq_pkg;

  // input command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REMOVE  = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_IGNORED = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_INSERTED = 3'd0;
  localparam logic [2:0] KIND_FIRED    = 3'd1;
  localparam logic [2:0] KIND_REMOVED  = 3'd2;
  localparam logic [2:0] KIND_NONE     = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_EV,
    ST_INS_MV_RD,
    ST_INS_MV_WR,
    ST_REM_RD,
    ST_REM_EV,
    ST_REM_MV_RD,
    ST_REM_MV_WR,
    ST_ADV_RD,
    ST_ADV_EV,
    ST_ADV_MV_RD,
    ST_ADV_MV_WR,
    ST_DONE_FULL,
    ST_DONE_INS,
    ST_DONE_NONE,
    ST_DONE_REM,
    ST_DONE_ADV
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_INS_RD,
    OP_INS_EV,
    OP_INS_MV_RD,
    OP_INS_MV_WR,
    OP_REM_RD,
    OP_REM_EV,
    OP_REM_MV_RD,
    OP_REM_MV_WR,
    OP_ADV_RD,
    OP_ADV_EV,
    OP_ADV_MV_RD,
    OP_ADV_MV_WR,
    OP_EMIT_FULL,
    OP_EMIT_INS,
    OP_EMIT_NONE,
    OP_EMIT_REM,
    OP_EMIT_ADV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;         // table holds ENTRIES timers
    logic idx_end;      // walk index reached occupancy
    logic fits;         // remaining amount covers the entry just read
    logic match;        // handle of the entry just read equals the key
    logic ins_mv_done;  // insert shift reached the insert slot
    logic rem_mv_done;  // remove shift reached the tail
    logic adv_mv_done;  // advance compaction finished
    logic pend_valid;   // a fired handle waits for its result beat
    logic out_free;     // result register can take a beat this cycle
  } dp_status_t;

endpackage

`default_nettype wire

[design/dtq_ram.sv]
// dtq_ram: generic single-write, single-read memory with registered read
// no dependencies
`default_nettype none

module dtq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[design/dtq_ctrl.sv]
// dtq_ctrl: sequencer of the delta timer queue
// depends on dtq_pkg; drives one datapath command per cycle from its status
`default_nettype none

module dtq_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cmd_valid,
  output logic                     cmd_ready,
  input  wire logic [1:0]          command,
  input  wire dtq_pkg::dp_status_t status,
  output dtq_pkg::dp_cmd_t         ctl_cmd
);

  dtq_pkg::state_t state;
  dtq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl_cmd.op = dtq_pkg::OP_NOP;
    cmd_ready  = 1'b0;
    unique case (state)
      dtq_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          ctl_cmd.op = dtq_pkg::OP_LOAD;
          unique case (command)
            dtq_pkg::CMD_INSERT: begin
              state_next = status.full ? dtq_pkg::ST_DONE_FULL : dtq_pkg::ST_INS_RD;
            end
            dtq_pkg::CMD_REMOVE:  state_next = dtq_pkg::ST_REM_RD;
            dtq_pkg::CMD_ADVANCE: state_next = dtq_pkg::ST_ADV_RD;
            default:              state_next = dtq_pkg::ST_IDLE;
          endcase
        end
      end
      // insert: walk to the slot, then shift the tail up by one
      dtq_pkg::ST_INS_RD: begin
        ctl_cmd.op = dtq_pkg::OP_INS_RD;
        state_next = status.idx_end ? dtq_pkg::ST_INS_MV_RD : dtq_pkg::ST_INS_EV;
      end
      dtq_pkg::ST_INS_EV: begin
        ctl_cmd.op = dtq_pkg::OP_INS_EV;
        state_next = status.fits ? dtq_pkg::ST_INS_RD : dtq_pkg::ST_INS_MV_RD;
      end
      dtq_pkg::ST_INS_MV_RD: begin
        ctl_cmd.op = dtq_pkg::OP_INS_MV_RD;
        state_next = status.ins_mv_done ? dtq_pkg::ST_DONE_INS : dtq_pkg::ST_INS_MV_WR;
      end
      dtq_pkg::ST_INS_MV_WR: begin
        ctl_cmd.op = dtq_pkg::OP_INS_MV_WR;
        state_next = dtq_pkg::ST_INS_MV_RD;
      end
      // remove: search the handle, then shift the tail down by one
      dtq_pkg::ST_REM_RD: begin
        ctl_cmd.op = dtq_pkg::OP_REM_RD;
        state_next = status.idx_end ? dtq_pkg::ST_DONE_NONE : dtq_pkg::ST_REM_EV;
      end
      dtq_pkg::ST_REM_EV: begin
        ctl_cmd.op = dtq_pkg::OP_REM_EV;
        state_next = status.match ? dtq_pkg::ST_REM_MV_RD : dtq_pkg::ST_REM_RD;
      end
      dtq_pkg::ST_REM_MV_RD: begin
        ctl_cmd.op = dtq_pkg::OP_REM_MV_RD;
        state_next = status.rem_mv_done ? dtq_pkg::ST_DONE_REM : dtq_pkg::ST_REM_MV_WR;
      end
      dtq_pkg::ST_REM_MV_WR: begin
        ctl_cmd.op = dtq_pkg::OP_REM_MV_WR;
        state_next = dtq_pkg::ST_REM_MV_RD;
      end
      // advance: pop fitting heads, then compact the rest to the front
      dtq_pkg::ST_ADV_RD: begin
        ctl_cmd.op = dtq_pkg::OP_ADV_RD;
        state_next = status.idx_end ? dtq_pkg::ST_ADV_MV_RD : dtq_pkg::ST_ADV_EV;
      end
      dtq_pkg::ST_ADV_EV: begin
        if (!(status.fits && status.pend_valid && !status.out_free)) begin
          ctl_cmd.op = dtq_pkg::OP_ADV_EV;
          state_next = status.fits ? dtq_pkg::ST_ADV_RD : dtq_pkg::ST_ADV_MV_RD;
        end
      end
      dtq_pkg::ST_ADV_MV_RD: begin
        ctl_cmd.op = dtq_pkg::OP_ADV_MV_RD;
        state_next = status.adv_mv_done ? dtq_pkg::ST_DONE_ADV : dtq_pkg::ST_ADV_MV_WR;
      end
      dtq_pkg::ST_ADV_MV_WR: begin
        ctl_cmd.op = dtq_pkg::OP_ADV_MV_WR;
        state_next = dtq_pkg::ST_ADV_MV_RD;
      end
      // final beats wait for room in the result register
      dtq_pkg::ST_DONE_FULL: begin
        if (status.out_free) begin
          ctl_cmd.op = dtq_pkg::OP_EMIT_FULL;
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_DONE_INS: begin
        if (status.out_free) begin
          ctl_cmd.op = dtq_pkg::OP_EMIT_INS;
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_DONE_NONE: begin
        if (status.out_free) begin
          ctl_cmd.op = dtq_pkg::OP_EMIT_NONE;
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_DONE_REM: begin
        if (status.out_free) begin
          ctl_cmd.op = dtq_pkg::OP_EMIT_REM;
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      dtq_pkg::ST_DONE_ADV: begin
        if (status.out_free) begin
          ctl_cmd.op = dtq_pkg::OP_EMIT_ADV;
          state_next = dtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dtq_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/dtq_dp.sv]
// dtq_dp: datapath of the delta timer queue
// depends on dtq_pkg and dtq_ram; holds the entry table, walk registers and result register
`default_nettype none

module dtq_dp #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_BITS  = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire dtq_pkg::dp_cmd_t ctl_cmd,
  output dtq_pkg::dp_status_t   status,
  input  wire logic [31:0]      amount,
  input  wire logic [15:0]      handle,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output logic [2:0]            kind,
  output logic [15:0]           fired_handle,
  output logic                  last
);

  localparam int OW = $clog2(ENTRIES + 1);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = COUNT_BITS;
  localparam int HW = HANDLE_BITS;
  localparam int DW = CW + HW;
  localparam logic [CW-1:0] CNT_MAX = '1;

  // walk and control registers
  logic [OW-1:0] occ;
  logic [OW-1:0] idx;
  logic [OW-1:0] cursor;
  logic [CW-1:0] cnt_amt;
  logic [HW-1:0] key;
  logic [CW-1:0] hold_delta;
  logic [HW-1:0] pend_handle;
  logic          pend_valid;

  // table port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic [CW-1:0] rd_delta;
  logic [HW-1:0] rd_handle;
  logic [CW:0]   amt_minus_rd;
  logic [CW-1:0] rd_minus_amt;
  logic [CW:0]   sum_w;
  logic [CW-1:0] sat_sum;
  logic [CW-1:0] amt_sat;
  logic [OW:0]   adv_src;
  logic [OW-1:0] cursor_dn;
  logic [OW-1:0] cursor_up;

  // result emission
  logic          emit;
  logic [2:0]    emit_kind;
  logic [15:0]   emit_handle;
  logic          emit_last;
  logic          out_free;

  dtq_ram #(
    .WIDTH (DW),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_delta     = ram_rdata[DW-1:HW];
  assign rd_handle    = ram_rdata[HW-1:0];
  assign amt_minus_rd = {1'b0, cnt_amt} - {1'b0, rd_delta};
  assign rd_minus_amt = rd_delta - cnt_amt;
  assign sum_w        = {1'b0, rd_delta} + {1'b0, hold_delta};
  assign sat_sum      = sum_w[CW] ? CNT_MAX : sum_w[CW-1:0];
  assign amt_sat      = ((amount >> COUNT_BITS) != 32'd0) ? CNT_MAX : CW'(amount);
  assign adv_src      = {1'b0, cursor} + {1'b0, idx};
  assign cursor_dn    = cursor - OW'(1);
  assign cursor_up    = cursor + OW'(1);
  assign out_free     = !res_valid || res_ready;

  always_comb begin
    status.full        = (occ == OW'(ENTRIES));
    status.idx_end     = (idx == occ);
    status.fits        = !amt_minus_rd[CW];
    status.match       = (rd_handle == key);
    status.ins_mv_done = (cursor == idx);
    status.rem_mv_done = (({1'b0, cursor} + (OW + 1)'(1)) >= {1'b0, occ});
    status.adv_mv_done = (adv_src == {1'b0, occ}) || ((idx == '0) && (cursor == OW'(1)));
    status.pend_valid  = pend_valid;
    status.out_free    = out_free;
  end

  // table access and result selection
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cursor[AW-1:0];
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = idx[AW-1:0];
    emit        = 1'b0;
    emit_kind   = dtq_pkg::KIND_NONE;
    emit_handle = '0;
    emit_last   = 1'b1;
    unique case (ctl_cmd.op)
      dtq_pkg::OP_INS_RD,
      dtq_pkg::OP_REM_RD,
      dtq_pkg::OP_ADV_RD: begin
        ram_re = !status.idx_end;
      end
      dtq_pkg::OP_INS_MV_RD: begin
        ram_re    = !status.ins_mv_done;
        ram_raddr = cursor_dn[AW-1:0];
      end
      dtq_pkg::OP_INS_MV_WR: begin
        ram_we = 1'b1;
        // the entry landing right after the new one gives up the new delay
        if (cursor_dn == idx) begin
          ram_wdata = {rd_minus_amt, rd_handle};
        end
      end
      dtq_pkg::OP_REM_MV_RD: begin
        ram_re    = !status.rem_mv_done;
        ram_raddr = cursor_up[AW-1:0];
      end
      dtq_pkg::OP_REM_MV_WR: begin
        ram_we = 1'b1;
        // successor of the removed entry takes over its delta
        if (cursor == idx) begin
          ram_wdata = {sat_sum, rd_handle};
        end
      end
      dtq_pkg::OP_ADV_EV: begin
        if (status.fits && pend_valid) begin
          emit        = 1'b1;
          emit_kind   = dtq_pkg::KIND_FIRED;
          emit_handle = 16'(pend_handle);
          emit_last   = 1'b0;
        end
      end
      dtq_pkg::OP_ADV_MV_RD: begin
        ram_re    = !status.adv_mv_done;
        ram_raddr = adv_src[AW-1:0];
      end
      dtq_pkg::OP_ADV_MV_WR: begin
        ram_we = 1'b1;
        // new head carries what is left of its delta
        if (cursor == '0) begin
          ram_wdata = {hold_delta, rd_handle};
        end
      end
      dtq_pkg::OP_EMIT_FULL: begin
        emit      = 1'b1;
        emit_kind = dtq_pkg::KIND_FULL;
      end
      dtq_pkg::OP_EMIT_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx[AW-1:0];
        ram_wdata = {cnt_amt, key};
        emit      = 1'b1;
        emit_kind = dtq_pkg::KIND_INSERTED;
      end
      dtq_pkg::OP_EMIT_NONE: begin
        emit      = 1'b1;
        emit_kind = dtq_pkg::KIND_NONE;
      end
      dtq_pkg::OP_EMIT_REM: begin
        emit        = 1'b1;
        emit_kind   = dtq_pkg::KIND_REMOVED;
        emit_handle = 16'(key);
      end
      dtq_pkg::OP_EMIT_ADV: begin
        emit = 1'b1;
        if (pend_valid) begin
          emit_kind   = dtq_pkg::KIND_FIRED;
          emit_handle = 16'(pend_handle);
        end
      end
      default: begin
      end
    endcase
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      occ        <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (ctl_cmd.op)
        dtq_pkg::OP_LOAD:     pend_valid <= 1'b0;
        dtq_pkg::OP_ADV_EV: begin
          if (status.fits) begin
            pend_valid <= 1'b1;
          end
        end
        dtq_pkg::OP_EMIT_INS: occ <= occ + OW'(1);
        dtq_pkg::OP_EMIT_REM: occ <= occ - OW'(1);
        dtq_pkg::OP_EMIT_ADV: occ <= occ - idx;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl_cmd.op)
      dtq_pkg::OP_LOAD: begin
        cnt_amt <= amt_sat;
        key     <= HW'(handle);
        idx     <= '0;
      end
      dtq_pkg::OP_INS_RD: cursor <= occ;
      dtq_pkg::OP_INS_EV: begin
        if (status.fits) begin
          cnt_amt <= amt_minus_rd[CW-1:0];
          idx     <= idx + OW'(1);
        end
      end
      dtq_pkg::OP_INS_MV_WR: cursor <= cursor_dn;
      dtq_pkg::OP_REM_EV: begin
        if (status.match) begin
          cursor     <= idx;
          hold_delta <= rd_delta;
        end else begin
          idx <= idx + OW'(1);
        end
      end
      dtq_pkg::OP_REM_MV_WR: cursor <= cursor_up;
      dtq_pkg::OP_ADV_RD:    cursor <= '0;
      dtq_pkg::OP_ADV_EV: begin
        if (status.fits) begin
          cnt_amt     <= amt_minus_rd[CW-1:0];
          idx         <= idx + OW'(1);
          pend_handle <= rd_handle;
        end else begin
          hold_delta <= rd_minus_amt;
        end
      end
      dtq_pkg::OP_ADV_MV_WR: cursor <= cursor_up;
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind         <= emit_kind;
      fired_handle <= emit_handle;
      last         <= emit_last;
    end
  end

endmodule

`default_nettype wire

[design/delta_timer_queue.sv]
// delta_timer_queue: top level of the sorted timer queue
// depends on dtq_pkg, dtq_ctrl, dtq_dp (which holds dtq_ram)
`default_nettype none

// A sorted queue of up to ENTRIES pending timers kept as a delta list: each
// stored entry holds a handle and its delay relative to the entry ahead of it.
// One command beat is taken on cmd_valid/cmd_ready; insert (command 0) places
// a timer after all timers of equal total time and answers with one inserted
// beat, or a table-full beat; remove (command 1) drops the first timer with the
// handle, folding its delta into its successor, and answers removed or not
// found; advance (command 2) pops every head whose delta fits into amount and
// sends one fired beat per timer in queue order, or a single none-fired beat.
// The last result beat of each command has last set; command 3 is dropped
// without any result. Amounts above the counter range saturate.
// Timing: the entries sit in one table with a registered read, so each entry
// that a command touches takes a read step, then an evaluate or write-back
// step. Results that res_ready holds back stall the command. One command is
// in flight at a time; cmd_ready is high only between commands, from the edge
// that loads the last result on, while that result may still wait in the
// output register. No clearing pass follows reset: only entries below the
// occupancy are read.

module delta_timer_queue #(
  parameter int ENTRIES     = 16,
  parameter int COUNT_BITS  = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command channel
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] amount,
  input  wire logic [15:0] handle,
  // result channel
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       kind,
  output logic [15:0]      fired_handle,
  output logic             last
);

  dtq_pkg::dp_cmd_t    ctl_cmd;
  dtq_pkg::dp_status_t status;

  // sequencer: one datapath command per cycle
  dtq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .command   (command),
    .status    (status),
    .ctl_cmd   (ctl_cmd)
  );

  // table, walk registers and the result register
  dtq_dp #(
    .ENTRIES     (ENTRIES),
    .COUNT_BITS  (COUNT_BITS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl_cmd      (ctl_cmd),
    .status       (status),
    .amount       (amount),
    .handle       (handle),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .kind         (kind),
    .fired_handle (fired_handle),
    .last         (last)
  );

`ifndef ASSERT_OFF
  // no stale result survives reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a real command keeps the queue busy for at least the next cycle
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready && command != dtq_pkg::CMD_IGNORED) |=> !cmd_ready)
    else $error("command beat taken while previous command still running");

  // only fired beats can be followed by more beats of the same command
  a_single_beat_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && kind != dtq_pkg::KIND_FIRED) |-> last)
    else $error("non-fired result without last");

  // results that name no timer carry a zero handle
  a_no_handle_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (kind == dtq_pkg::KIND_INSERTED || kind == dtq_pkg::KIND_NONE ||
                   kind == dtq_pkg::KIND_FULL)) |-> (fired_handle == 16'd0))
    else $error("handle set on a result that names no timer");
`endif

endmodule

`default_nettype wire
